### rtl/cobs_pkg.sv
// Shared types and constants for the COBS joystick packet receiver.
// No dependencies.
package cobs_pkg;

    localparam int MAX_DECODED_DEFAULT = 64;
    localparam int HEAD_BYTES = 5;
    localparam logic [31:0] POS_ONE = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE = 32'hBF80_0000;
    localparam logic [7:0] TYPE_A_RESET = 8'hC0;
    localparam logic [7:0] TYPE_B_RESET = 8'hC1;

    // Configuration register indexes
    localparam logic [0:0] REG_TYPE_A = 1'b0;
    localparam logic [0:0] REG_TYPE_B = 1'b1;

    // Outcome codes
    typedef enum logic [1:0] {
        OUT_UPDATED  = 2'd0,
        OUT_DECODE   = 2'd1,
        OUT_UNKNOWN  = 2'd2,
        OUT_NAN      = 2'd3
    } outcome_t;

    // Closed frame handed from the decoder to the packet stage
    typedef struct packed {
        logic        bad;      // ended inside a block, overflowed or empty
        logic        short_pk; // fewer than five decoded bytes
        logic [39:0] head;     // first five decoded bytes, byte 0 lowest
    } frame_t;

    // Result item
    typedef struct packed {
        logic [31:0] latest_a;
        logic [31:0] latest_b;
        logic [31:0] packet_total;
        logic [31:0] value_bits;
        logic [1:0]  outcome;
        logic        channel;
        logic        link_up;
    } result_t;

endpackage

### rtl/cobs_joystick_packet_receiver_top.sv
// Top level of the COBS joystick packet receiver.
// Depends on cobs_pkg, cobs_byte_front, cobs_fifo, cobs_packet.
//
// Usage:
//   s_axis: one received link byte per beat; 0x00 closes a frame.
//   m_axis: one result beat per closed nonempty frame (outcome, channel,
//   clamped value, stored channel values, packet count, link flag).
//   cfg: writes type_code_a (index 0) and type_code_b (index 1); always ready.
// Throughput: one byte per cycle. The decoder updates its block state for
//   each byte, so s_axis_tready stays high unless the frame
//   queue (two entries) is full and the byte is a frame delimiter.
// Path: a closed frame is written into the queue, then taken into the result register.
// Reset: aresetn low clears decode state, stored values, count and link
//   flag, and restores the type codes to 0xC0 and 0xC1.
// Stall: while m_axis_tready is low the result holds; queued frames wait,
//   and non-delimiter bytes keep flowing until a delimiter finds the
//   queue full.
module cobs_joystick_packet_receiver_top #(
    parameter int MAX_DECODED = cobs_pkg::MAX_DECODED_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] outcome, [2] channel, [34:3] value_bits, [66:35] latest_a,
    // [98:67] latest_b, [130:99] packet_total, [131] link_up, [135:132] zero
    output logic [135:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [7:0]   cfg_data
);
    import cobs_pkg::*;

    logic [7:0] type_a_reg, type_b_reg;
    logic       dec_in, frm_valid, q_ready, q_valid, pk_ready;
    frame_t     frm, q_frame;
    result_t    res;
    logic       is_delim;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_a_reg <= TYPE_A_RESET;
            type_b_reg <= TYPE_B_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TYPE_A: type_a_reg <= cfg_data;
                REG_TYPE_B: type_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign is_delim      = (s_axis_tdata == 8'd0);
    assign s_axis_tready = !is_delim || q_ready;
    assign dec_in        = s_axis_tvalid && s_axis_tready;

    cobs_byte_front #(.MAX_DECODED(MAX_DECODED)) u_decode (
        .aclk, .aresetn,
        .in_valid(dec_in), .in_byte(s_axis_tdata),
        .frame_valid(frm_valid), .frame(frm)
    );

    cobs_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid(frm_valid), .wr_data(frm), .wr_ready(q_ready),
        .rd_valid(q_valid), .rd_ready(pk_ready), .rd_data(q_frame)
    );

    cobs_packet u_packet (
        .aclk, .aresetn,
        .type_code_a(type_a_reg), .type_code_b(type_b_reg),
        .in_valid(q_valid), .in_ready(pk_ready), .frame(q_frame),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .result(res)
    );

    assign m_axis_tdata = {4'd0, res.link_up, res.packet_total, res.latest_b,
                           res.latest_a, res.value_bits, res.channel, res.outcome};

    a_frame_room: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_valid |-> q_ready) else $error("frame lost at queue");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_cfg_a: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_index == REG_TYPE_A |=> type_a_reg == $past(cfg_data))
        else $error("type code a not written");

endmodule

### rtl/cobs_decode.sv
// Front part: byte-wise COBS decoder; emits one frame record per closed frame.
// Depends on cobs_pkg.
module cobs_byte_front #(
    parameter int MAX_DECODED = cobs_pkg::MAX_DECODED_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    output logic                 frame_valid,
    output cobs_pkg::frame_t     frame
);
    import cobs_pkg::*;

    localparam int CW = $clog2(MAX_DECODED + 1);

    logic [7:0]    block_left_reg;
    logic          block_full_reg;
    logic [CW-1:0] out_count_reg;
    logic          frame_error_reg;
    logic          frame_open_reg;
    logic [39:0]   head_reg;

    logic          put;
    logic [7:0]    put_byte;
    logic          is_code;

    assign is_code  = (block_left_reg == 8'd0);
    assign put      = in_valid && (in_byte != 8'd0) &&
                      (!is_code || (frame_open_reg && !block_full_reg));
    assign put_byte = is_code ? 8'd0 : in_byte;

    assign frame_valid    = in_valid && (in_byte == 8'd0) && frame_open_reg;
    assign frame.bad      = (block_left_reg != 8'd0) || frame_error_reg ||
                            (out_count_reg == '0);
    assign frame.short_pk = (out_count_reg < CW'(HEAD_BYTES));
    assign frame.head     = head_reg;

    // Advance decode state per byte; clear on delimiter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_left_reg  <= '0;
            block_full_reg  <= 1'b0;
            out_count_reg   <= '0;
            frame_error_reg <= 1'b0;
            frame_open_reg  <= 1'b0;
            head_reg        <= '0;
        end else if (in_valid) begin
            if (in_byte == 8'd0) begin
                block_left_reg  <= '0;
                block_full_reg  <= 1'b0;
                out_count_reg   <= '0;
                frame_error_reg <= 1'b0;
                frame_open_reg  <= 1'b0;
                head_reg        <= '0;
            end else begin
                frame_open_reg <= 1'b1;
                if (is_code) begin
                    block_left_reg <= in_byte - 8'd1;
                    block_full_reg <= (in_byte == 8'hFF);
                end else begin
                    block_left_reg <= block_left_reg - 8'd1;
                end
                if (put) begin
                    if (out_count_reg < CW'(MAX_DECODED)) begin
                        if (out_count_reg < CW'(HEAD_BYTES))
                            head_reg[out_count_reg[2:0]*8 +: 8] <= put_byte;
                        out_count_reg <= out_count_reg + CW'(1);
                    end else begin
                        frame_error_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // A delimiter-closed frame always reports emptiness as bad
    a_empty_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_valid && out_count_reg == '0 |-> frame.bad)
        else $error("empty frame not flagged");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_byte == 8'd0 |=> !frame_open_reg && out_count_reg == '0)
        else $error("frame state not cleared");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        out_count_reg <= CW'(MAX_DECODED))
        else $error("decoded count past limit");

endmodule

### rtl/cobs_fifo.sv
// Two-entry queue for frame records between decoder and packet stage.
// Depends on cobs_pkg.
module cobs_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    input  cobs_pkg::frame_t wr_data,
    output logic             wr_ready,
    output logic             rd_valid,
    input  logic             rd_ready,
    output cobs_pkg::frame_t rd_data
);
    import cobs_pkg::*;

    frame_t     mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // Store entry
    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("queue count overflow");
    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        wr && !rd |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("push lost");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        rd && !wr |=> cnt_reg == $past(cnt_reg) - 2'd1) else $error("pop lost");

endmodule

### rtl/cobs_packet.sv
// Back part: classifies a frame, clamps the value, updates channel state.
// Depends on cobs_pkg.
module cobs_packet (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        type_code_a,
    input  logic [7:0]        type_code_b,
    input  logic              in_valid,
    output logic              in_ready,
    input  cobs_pkg::frame_t  frame,
    output logic              out_valid,
    input  logic              out_ready,
    output cobs_pkg::result_t result
);
    import cobs_pkg::*;

    logic [31:0] stored_a_reg, stored_b_reg, total_reg;
    logic        seen_reg;
    logic        out_valid_reg;
    result_t     res_reg;

    logic        is_a, is_b, is_nan, take;
    logic [31:0] v, vc;
    outcome_t    oc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign result    = res_reg;
    assign take      = in_valid && in_ready;

    // Classify and clamp
    always_comb begin
        is_a   = (frame.head[7:0] == type_code_a);
        is_b   = (frame.head[7:0] == type_code_b);
        v      = frame.head[39:8];
        is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
        if (!v[31]) vc = (v > POS_ONE) ? POS_ONE : v;
        else        vc = (v > NEG_ONE) ? NEG_ONE : v;
        if (frame.bad)                               oc = OUT_DECODE;
        else if ((!is_a && !is_b) || frame.short_pk) oc = OUT_UNKNOWN;
        else if (is_nan)                             oc = OUT_NAN;
        else                                         oc = OUT_UPDATED;
    end

    // Update state and hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_a_reg  <= '0;
            stored_b_reg  <= '0;
            total_reg     <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_ready) out_valid_reg <= 1'b0;
            if (take) begin
                out_valid_reg <= 1'b1;
                if (oc == OUT_UPDATED) begin
                    if (is_a) stored_a_reg <= vc;
                    else      stored_b_reg <= vc;
                    total_reg <= total_reg + 32'd1;
                    seen_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg.outcome      <= oc;
            res_reg.channel      <= (oc == OUT_UPDATED) && !is_a;
            res_reg.value_bits   <= (oc == OUT_UPDATED) ? vc : 32'd0;
            res_reg.latest_a     <= (oc == OUT_UPDATED && is_a) ? vc : stored_a_reg;
            res_reg.latest_b     <= (oc == OUT_UPDATED && !is_a) ? vc : stored_b_reg;
            res_reg.packet_total <= total_reg + ((oc == OUT_UPDATED) ? 32'd1 : 32'd0);
            res_reg.link_up      <= seen_reg || (oc == OUT_UPDATED);
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |=> out_valid_reg) else $error("result dropped");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        take && oc == OUT_UPDATED |=> total_reg == $past(total_reg) + 32'd1)
        else $error("count not advanced");
    a_link: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg != 32'd0 |-> seen_reg) else $error("link flag missing");

endmodule
